// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that one condition implies another on the next clock edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/hbi2x_pkg.sv -----
package hbi2x_pkg;

    localparam int DelayDepth  = 31;
    localparam int FlushLength = 63;
    localparam int OddTaps     = DelayDepth + 1;
    localparam int CentreDelay = (DelayDepth + 1) / 2;
    localparam int FlushRounds = FlushLength / 2;
    localparam int MacSteps    = OddTaps + 1;

    localparam int SampleW  = 16;
    localparam int OutW     = 18;
    localparam int CoefW    = 32;
    localparam int ProdW    = CoefW + SampleW;
    localparam int AccW     = ProdW + 4;
    localparam int RoundSh  = 31;
    localparam int TapIdxW  = $clog2(OddTaps);
    localparam int MacCntW  = $clog2(MacSteps + 1);
    localparam int RoundCntW = $clog2(FlushRounds + 1);

    localparam logic signed [AccW-1:0] RoundHalf = AccW'(64'sd1 <<< (RoundSh - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVEN,
        ST_MAC,
        ST_ODD,
        ST_SHIFT,
        ST_FINAL
    } hbi2x_state_t;

    typedef struct packed {
        logic load;
        logic mac_clear;
        logic mac_step;
        logic emit_even;
        logic emit_odd;
        logic emit_final;
        logic odd_last;
        logic shift;
        logic clear_line;
    } hbi2x_cmd_t;

    typedef struct packed {
        logic mac_done;
        logic out_free;
    } hbi2x_status_t;

    // Odd-phase taps h[1], h[3], ..., h[63]; the second half mirrors the first.
    function automatic logic signed [CoefW-1:0] odd_coef(input logic [TapIdxW-1:0] idx);
        logic [TapIdxW-2:0] k;
        logic signed [CoefW-1:0] c;
        k = idx[TapIdxW-1] ? ~idx[TapIdxW-2:0] : idx[TapIdxW-2:0];
        unique case (k)
            4'd0:    c = -32'sd259341;
            4'd1:    c = 32'sd800800;
            4'd2:    c = -32'sd1846783;
            4'd3:    c = 32'sd3656617;
            4'd4:    c = -32'sd6559276;
            4'd5:    c = 32'sd10961781;
            4'd6:    c = -32'sd17364505;
            4'd7:    c = 32'sd26393630;
            4'd8:    c = -32'sd38871571;
            4'd9:    c = 32'sd55970269;
            4'd10:   c = -32'sd79554954;
            4'd11:   c = 32'sd113013354;
            4'd12:   c = -32'sd163534336;
            4'd13:   c = 32'sd249878515;
            4'd14:   c = -32'sd441236499;
            default: c = 32'sd1362294123;
        endcase
        return c;
    endfunction

endpackage

// ----- src/hbi2x_dp.sv -----
`include "assert_macros.svh"

module hbi2x_dp
    import hbi2x_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  hbi2x_cmd_t                 cmd,
    output hbi2x_status_t              status,
    input  logic                       kind,
    input  logic signed [SampleW-1:0]  sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OutW-1:0]     out_sample,
    output logic                       last
);

    logic signed [SampleW-1:0] dl_reg [DelayDepth];
    logic signed [SampleW-1:0] x_reg;
    logic signed [ProdW-1:0]   prod_reg;
    logic signed [AccW-1:0]    acc_reg;
    logic [MacCntW-1:0]        mac_cnt_reg;
    logic                      out_valid_reg;
    logic signed [OutW-1:0]    out_sample_reg;
    logic                      last_reg;

    logic [TapIdxW-1:0]        tap_idx;
    logic signed [SampleW-1:0] tap_val;
    logic signed [ProdW-1:0]   prod_next;
    logic signed [AccW-1:0]    odd_round;
    logic signed [OutW-1:0]    even_val;
    logic                      emit;

    always_comb
    begin
        tap_idx = mac_cnt_reg[TapIdxW-1:0];
        if (tap_idx == '0)
        begin
            tap_val = x_reg;
        end
        else
        begin
            tap_val = dl_reg[tap_idx - TapIdxW'(1)];
        end
        prod_next = odd_coef(tap_idx) * tap_val;
        odd_round = acc_reg + (acc_reg[AccW-1] ? (RoundHalf - AccW'(1)) : RoundHalf);
        // The centre tap is 2^31 - 1, which rounds back to the sample itself.
        even_val  = OutW'(dl_reg[CentreDelay-1]);
        emit      = cmd.emit_even | cmd.emit_odd | cmd.emit_final;
    end

    assign status.mac_done = (mac_cnt_reg == MacCntW'(MacSteps));
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mac_cnt_reg   <= '0;
            for (int i = 0; i < DelayDepth; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.mac_clear)
            begin
                mac_cnt_reg <= '0;
            end
            else if (cmd.mac_step)
            begin
                mac_cnt_reg <= mac_cnt_reg + MacCntW'(1);
            end

            if (cmd.clear_line)
            begin
                for (int i = 0; i < DelayDepth; i++)
                begin
                    dl_reg[i] <= '0;
                end
            end
            else if (cmd.shift)
            begin
                for (int i = 1; i < DelayDepth; i++)
                begin
                    dl_reg[i] <= dl_reg[i-1];
                end
                dl_reg[0] <= x_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= kind ? '0 : sample;
        end

        if (cmd.mac_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mac_step)
        begin
            if (mac_cnt_reg < MacCntW'(OddTaps))
            begin
                prod_reg <= prod_next;
            end
            if (mac_cnt_reg != '0)
            begin
                acc_reg <= acc_reg + AccW'(prod_reg);
            end
        end

        if (cmd.emit_even)
        begin
            out_sample_reg <= even_val;
            last_reg       <= 1'b0;
        end
        else if (cmd.emit_odd)
        begin
            out_sample_reg <= odd_round[RoundSh +: OutW];
            last_reg       <= cmd.odd_last;
        end
        else if (cmd.emit_final)
        begin
            out_sample_reg <= '0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign last       = last_reg;

    `ASSERT_CLK(a_emit_when_free, !emit || !out_valid_reg || out_ready, "beat overwritten")
    `ASSERT_CLK(a_no_step_past_done, !(cmd.mac_step && status.mac_done), "step after done")

endmodule

// ----- src/hbi2x_ctrl.sv -----
`include "assert_macros.svh"

module hbi2x_ctrl
    import hbi2x_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          kind,
    input  hbi2x_status_t status,
    output hbi2x_cmd_t    cmd
);

    hbi2x_state_t           state_reg;
    hbi2x_state_t           state_next;
    logic                   is_flush_reg;
    logic                   is_flush_next;
    logic [RoundCntW-1:0]   rounds_reg;
    logic [RoundCntW-1:0]   rounds_next;

    always_comb
    begin
        state_next    = state_reg;
        is_flush_next = is_flush_reg;
        rounds_next   = rounds_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = ST_EVEN;
                    is_flush_next = kind;
                    rounds_next   = RoundCntW'(FlushRounds);
                end
            end
            ST_EVEN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (status.mac_done)
                begin
                    state_next = ST_ODD;
                end
            end
            ST_ODD:
            begin
                if (status.out_free)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (!is_flush_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (rounds_reg == RoundCntW'(1))
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next  = ST_EVEN;
                    rounds_next = rounds_reg - RoundCntW'(1);
                end
            end
            ST_FINAL:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cmd.odd_last = !is_flush_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load      = in_valid;
                cmd.mac_clear = in_valid;
            end
            ST_EVEN:
            begin
                cmd.emit_even = status.out_free;
            end
            ST_MAC:
            begin
                cmd.mac_step = !status.mac_done;
            end
            ST_ODD:
            begin
                cmd.emit_odd = status.out_free;
            end
            ST_SHIFT:
            begin
                cmd.shift     = 1'b1;
                cmd.mac_clear = 1'b1;
            end
            ST_FINAL:
            begin
                cmd.emit_final = status.out_free;
                cmd.clear_line = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            is_flush_reg <= 1'b0;
            rounds_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            is_flush_reg <= is_flush_next;
            rounds_reg   <= rounds_next;
        end
    end

    `ASSERT_CLK(a_final_only_on_flush, state_reg != ST_FINAL || is_flush_reg, "stray final beat")
    `ASSERT_NEXT(a_accept_starts_even, in_valid && in_ready, state_reg == ST_EVEN, "no start")

endmodule

// ----- src/halfband_interpolator_2x_top.sv -----
// Channel | Handshake            | Payload
// input   | in_valid, in_ready   | kind, sample
// output  | out_valid, out_ready | out_sample, last
//
// A sample item runs through the accept, the even beat, the shared 32x16
// multiply-accumulate (32 taps, then draining the product and finishing), the odd beat
// and the delay line shift; only then is the next item accepted.
// A flush item runs 31 such rounds after its accept and ends with a final zero beat.
// Reset clears the delay line at once; no clearing pass is needed.
// A stalled output holds the controller in its emit state until the beat leaves.
module halfband_interpolator_2x_top
    import hbi2x_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic signed [SampleW-1:0] sample,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [OutW-1:0]    out_sample,
    output logic                      last
);

    hbi2x_cmd_t    cmd;
    hbi2x_status_t status;

    hbi2x_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    hbi2x_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .kind       (kind),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .last       (last)
    );

endmodule

// ----- dv/halfband_interpolator_2x_top_tb.sv -----
`timescale 1ns / 100ps

module halfband_interpolator_2x_top_tb;
    import hbi2x_pkg::*;

    localparam int IdleLimit = 5000;
    localparam int LongHold  = 400;

    // First half of the odd-phase taps; the second half mirrors it.
    localparam longint HalfTaps [16] = '{
        -259341, 800800, -1846783, 3656617, -6559276, 10961781,
        -17364505, 26393630, -38871571, 55970269, -79554954, 113013354,
        -163534336, 249878515, -441236499, 1362294123
    };

    typedef struct {
        logic signed [OutW-1:0] value;
        logic                   last;
    } out_beat_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      kind;
    logic signed [SampleW-1:0] sample;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [OutW-1:0]    out_sample;
    logic                      last;

    out_beat_t                 pending_beats [$];
    logic signed [SampleW-1:0] history [DelayDepth];
    out_beat_t                 head_beat;
    int                        errors = 0;
    int                        idle_cycles = 0;
    int                        rx_hold_len = 0;
    bit                        quiet_tx = 1'b0;
    bit                        quiet_rx = 1'b0;

    halfband_interpolator_2x_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .last       (last)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic longint odd_phase_tap(input int p);
        return HalfTaps[(p < OddTaps / 2) ? p : (OddTaps - 1 - p)];
    endfunction

    function automatic logic signed [OutW-1:0] round_q31(input longint acc);
        longint r;
        if (acc >= 0)
        begin
            r = (acc + 64'sd1073741824) / 64'sd2147483648;
        end
        else
        begin
            r = -((-acc + 64'sd1073741824) / 64'sd2147483648);
        end
        return r[OutW-1:0];
    endfunction

    function automatic logic signed [SampleW-1:0] full_scale_for(input int p);
        return (odd_phase_tap(p) >= 0) ? 16'sh7fff : 16'sh8000;
    endfunction

    // Computes the even and odd beats for one sample and shifts it into the history.
    task automatic interpolate_sample(input logic signed [SampleW-1:0] x,
                                      input logic mark_last);
        longint    even_acc;
        longint    odd_acc;
        longint    v;
        out_beat_t b;
        even_acc = 64'sd2147483647 * longint'(history[CentreDelay - 1]);
        odd_acc  = 0;
        for (int p = 0; p < OddTaps; p++)
        begin
            v = (p == 0) ? longint'(x) : longint'(history[p - 1]);
            odd_acc += odd_phase_tap(p) * v;
        end
        b.value = round_q31(even_acc);
        b.last  = 1'b0;
        pending_beats.push_back(b);
        b.value = round_q31(odd_acc);
        b.last  = mark_last;
        pending_beats.push_back(b);
        for (int i = DelayDepth - 1; i > 0; i--)
        begin
            history[i] = history[i - 1];
        end
        history[0] = x;
    endtask

    task automatic predict_item(input logic k, input logic signed [SampleW-1:0] s);
        out_beat_t b;
        if (k == 1'b0)
        begin
            interpolate_sample(s, 1'b1);
        end
        else
        begin
            for (int i = 0; i < FlushLength / 2; i++)
            begin
                interpolate_sample('0, 1'b0);
            end
            b.value = '0;
            b.last  = 1'b1;
            pending_beats.push_back(b);
            for (int i = 0; i < DelayDepth; i++)
            begin
                history[i] = '0;
            end
        end
    endtask

    // Offers one beat and returns at the edge where it is accepted.
    task automatic send_item(input logic k, input logic signed [SampleW-1:0] s);
        int gap;
        gap = pick_gap(quiet_tx);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        sample   <= s;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_item(k, s);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
    endtask

    task automatic test_flush_after_reset();
        send_item(1'b1, 16'sh1234);
        drain_results();
    endtask

    task automatic test_impulses();
        send_item(1'b0, 16'sh7fff);
        send_item(1'b1, 16'sh0000);
        send_item(1'b0, 16'sh8000);
        send_item(1'b1, 16'shffff);
    endtask

    task automatic test_small_values();
        send_item(1'b0, 16'sd1);
        send_item(1'b0, -16'sd1);
        send_item(1'b0, 16'sd0);
        send_item(1'b0, 16'sd2);
        send_item(1'b0, -16'sd2);
        send_item(1'b1, 16'sh8000);
    endtask

    task automatic test_back_to_back_flush();
        quiet_tx = 1'b1;
        send_item(1'b0, 16'sh5a5a);
        send_item(1'b1, 16'sh7fff);
        send_item(1'b1, 16'sh0000);
        quiet_tx = 1'b0;
        drain_results();
    endtask

    task automatic test_output_backpressure();
        quiet_tx    = 1'b1;
        rx_hold_len = LongHold;
        for (int i = 0; i < 20; i++)
        begin
            send_item(1'b0, 16'($urandom));
        end
        quiet_tx = 1'b0;
        drain_results();
    endtask

    task automatic test_random_streams(input int n_items);
        int sent;
        int len;
        int r;
        logic signed [SampleW-1:0] s;
        sent = 0;
        while (sent < n_items)
        begin
            quiet_tx = ($urandom_range(0, 4) == 0);
            quiet_rx = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                for (int i = 0; i < OddTaps; i++)
                begin
                    send_item(1'b0, full_scale_for(OddTaps - 1 - i));
                end
                sent += OddTaps;
            end
            else
            begin
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                    begin
                        s = 16'($urandom);
                    end
                    else if (r < 80)
                    begin
                        s = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
                    end
                    else
                    begin
                        s = 16'($signed($urandom_range(0, 128)) - 64);
                    end
                    send_item(1'b0, s);
                end
                sent += len;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                send_item(1'b1, 16'($urandom));
                sent++;
            end
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < DelayDepth; i++)
        begin
            history[i] = '0;
        end
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        kind     <= 1'b0;
        sample   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_flush_after_reset();
        test_impulses();
        test_small_values();
        test_back_to_back_flush();
        test_output_backpressure();
        test_random_streams(120);
        drain_results();
        repeat (60) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        int len;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                len         = rx_hold_len;
                rx_hold_len = 0;
            end
            else
            begin
                len = pick_gap(quiet_rx);
            end
            if (len > 0)
            begin
                out_ready <= 1'b0;
                repeat (len) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, actual out_sample %0d last %0b",
                         $time, out_sample, last);
                errors++;
            end
            else
            begin
                head_beat = pending_beats.pop_front();
                if (out_sample !== head_beat.value)
                begin
                    $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                             $time, head_beat.value, out_sample);
                    errors++;
                end
                if (last !== head_beat.last)
                begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, head_beat.last, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IdleLimit)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, IdleLimit);
            $display("FAIL");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/hbi2x_pkg.sv
src/hbi2x_dp.sv
src/hbi2x_ctrl.sv
src/halfband_interpolator_2x_top.sv
dv/halfband_interpolator_2x_top_tb.sv
